FILE: rtl/nil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nil_pkg: shared types and constants of the number/identifier lexer
// Lexer modes, result kinds, character codes and the result bundle that
// travels from the step logic to the output stage.
// ----------------------------------------------------------------------------
package nil_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FIELD_BITS = 16;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUM     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_SKIP    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NUM   = 2'd0,
        KIND_IDENT = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    localparam logic [7:0] CH_DIGIT_LO = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI = 8'd57;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7A;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;

    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [FIELD_BITS-1:0] line_no;
        logic [FIELD_BITS-1:0] col_no;
        logic [FIELD_BITS-1:0] tok_len;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/nil_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nil_if: request channels of the lexer
// Character channel into the lexer and token channel out of it, both with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface nil_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface nil_tok_if;
    logic                           valid;
    logic                           ready;
    nil_pkg::kind_t                 kind;
    logic [nil_pkg::FIELD_BITS-1:0] line_no;
    logic [nil_pkg::FIELD_BITS-1:0] col_no;
    logic [nil_pkg::FIELD_BITS-1:0] tok_len;

    modport source (output valid, output kind, output line_no, output col_no,
                    output tok_len, input ready);
    modport sink   (input valid, input kind, input line_no, input col_no,
                    input tok_len, output ready);
endinterface
`default_nettype wire

FILE: rtl/number_identifier_lexer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// number_identifier_lexer_unit: number and identifier lexer
// Character-class lexer that turns a byte stream into number, identifier
// and malformed-symbol results with line, column and length.
// ----------------------------------------------------------------------------
// The lexer takes one character request per clock cycle while char_in.ready
// is high and registers at most one token request per character. The mode
// and the line, column, token-start and run-length counters sit in registers
// that the step logic updates in a single pass, so a character can follow in
// every cycle. Results land in an output register backed by a one-entry skid
// register: char_in.ready is low only while that skid register is full,
// which happens when the sink stalls and two results are pending. Digits form
// number tokens; a letter followed by letters or digits forms an identifier.
// A run ends at space, tab, newline, '#' or end of input; '#' then opens a
// comment to the end of the line. Any other character gives a malformed
// result (length 0, column of that character) and the rest of the word is
// dropped up to the next blank or newline. The first character of a line is
// in column 1, the first line is line 1. Counters are COUNT_BITS wide and
// saturate; reported fields clamp at 65535. End of input flushes a pending
// token and returns every counter to its reset value.
// ----------------------------------------------------------------------------
module number_identifier_lexer_unit #(
    parameter int COUNT_BITS = nil_pkg::COUNT_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    nil_char_if.sink  char_in,
    nil_tok_if.source tok_out
);

    // Lexer state
    nil_pkg::mode_t        mode_reg,  mode_next;
    logic [COUNT_BITS-1:0] line_reg,  line_next;
    logic [COUNT_BITS-1:0] col_reg,   col_next;
    logic [COUNT_BITS-1:0] start_reg, start_next;
    logic [COUNT_BITS-1:0] run_reg,   run_next;

    // Output register and skid register
    nil_pkg::result_t step_result;
    nil_pkg::result_t out_reg;
    nil_pkg::result_t skid_reg;

    logic accept;
    logic push;
    logic pop;

    // Hold off new characters only while the skid register is occupied
    assign char_in.ready = ~skid_reg.valid;
    assign accept        = char_in.valid & char_in.ready;
    assign push          = accept & step_result.valid;
    assign pop           = out_reg.valid & tok_out.ready;

    nil_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .ch           (char_in.ch),
        .end_of_input (char_in.end_of_input),
        .mode         (mode_reg),
        .line_count   (line_reg),
        .column_count (col_reg),
        .start_column (start_reg),
        .run_length   (run_reg),
        .mode_next    (mode_next),
        .line_next    (line_next),
        .column_next  (col_next),
        .start_next   (start_next),
        .run_next     (run_next),
        .result       (step_result)
    );

    // Advance the lexer state on every accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= nil_pkg::MODE_IDLE;
            line_reg  <= COUNT_BITS'(1);
            col_reg   <= '0;
            start_reg <= '0;
            run_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            run_reg   <= run_next;
        end
    end

    // Result queue: the output register drains first, the skid register
    // refills it when the sink takes a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (skid_reg.valid)
        begin
            if (pop)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_reg.valid || pop)
                out_reg <= step_result;
            else
                skid_reg <= step_result;
        end
        else if (pop)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign tok_out.valid   = out_reg.valid;
    assign tok_out.kind    = out_reg.kind;
    assign tok_out.line_no = out_reg.line_no;
    assign tok_out.col_no  = out_reg.col_no;
    assign tok_out.tok_len = out_reg.tok_len;

endmodule
`default_nettype wire

FILE: rtl/nil_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nil_step: one-character lexer step
// Classify the character, compute the next mode and counters, and form the
// result request, if any.
// ----------------------------------------------------------------------------
module nil_step #(
    parameter int COUNT_BITS = nil_pkg::COUNT_BITS
) (
    input  wire logic [7:0]            ch,
    input  wire logic                  end_of_input,
    input  wire nil_pkg::mode_t        mode,
    input  wire logic [COUNT_BITS-1:0] line_count,
    input  wire logic [COUNT_BITS-1:0] column_count,
    input  wire logic [COUNT_BITS-1:0] start_column,
    input  wire logic [COUNT_BITS-1:0] run_length,
    output nil_pkg::mode_t             mode_next,
    output logic [COUNT_BITS-1:0]      line_next,
    output logic [COUNT_BITS-1:0]      column_next,
    output logic [COUNT_BITS-1:0]      start_next,
    output logic [COUNT_BITS-1:0]      run_next,
    output nil_pkg::result_t           result
);

    localparam int FB = nil_pkg::FIELD_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic is_digit, is_letter, is_blank, is_hash, is_newline;
    logic [COUNT_BITS-1:0] line_inc, col_inc, run_inc;
    logic [COUNT_BITS+FB-1:0] line_ext, start_ext, run_ext, col_ext;
    logic [FB-1:0] line_out, start_out, run_out, col_out;
    logic in_run;
    nil_pkg::kind_t run_kind;

    assign is_digit   = (ch >= nil_pkg::CH_DIGIT_LO) && (ch <= nil_pkg::CH_DIGIT_HI);
    assign is_letter  = ((ch >= nil_pkg::CH_UPPER_LO) && (ch <= nil_pkg::CH_UPPER_HI))
                     || ((ch >= nil_pkg::CH_LOWER_LO) && (ch <= nil_pkg::CH_LOWER_HI));
    assign is_blank   = (ch == nil_pkg::CH_SPACE) || (ch == nil_pkg::CH_TAB);
    assign is_hash    = (ch == nil_pkg::CH_HASH);
    assign is_newline = (ch == nil_pkg::CH_NEWLINE);

    // Saturating increments
    assign line_inc = (&line_count)   ? line_count   : line_count + CNT_ONE;
    assign col_inc  = (&column_count) ? column_count : column_count + CNT_ONE;
    assign run_inc  = (&run_length)   ? run_length   : run_length + CNT_ONE;

    // Clamp counters to the 16-bit result fields
    assign line_ext  = {{FB{1'b0}}, line_count};
    assign start_ext = {{FB{1'b0}}, start_column};
    assign run_ext   = {{FB{1'b0}}, run_length};
    assign col_ext   = {{FB{1'b0}}, col_inc};
    assign line_out  = (|line_ext[COUNT_BITS+FB-1:FB])  ? '1 : line_ext[FB-1:0];
    assign start_out = (|start_ext[COUNT_BITS+FB-1:FB]) ? '1 : start_ext[FB-1:0];
    assign run_out   = (|run_ext[COUNT_BITS+FB-1:FB])   ? '1 : run_ext[FB-1:0];
    assign col_out   = (|col_ext[COUNT_BITS+FB-1:FB])   ? '1 : col_ext[FB-1:0];

    assign in_run   = (mode == nil_pkg::MODE_NUM) || (mode == nil_pkg::MODE_IDENT);
    assign run_kind = (mode == nil_pkg::MODE_NUM) ? nil_pkg::KIND_NUM : nil_pkg::KIND_IDENT;

    always_comb
    begin
        mode_next      = mode;
        line_next      = line_count;
        column_next    = column_count;
        start_next     = start_column;
        run_next       = run_length;
        result.valid   = 1'b0;
        result.kind    = run_kind;
        result.line_no = line_out;
        result.col_no  = start_out;
        result.tok_len = run_out;

        if (end_of_input)
        begin
            // Flush a pending token, then return to the reset state
            result.valid = in_run;
            mode_next    = nil_pkg::MODE_IDLE;
            line_next    = CNT_ONE;
            column_next  = '0;
            start_next   = '0;
            run_next     = '0;
        end
        else if (is_newline)
        begin
            result.valid = in_run;
            mode_next    = nil_pkg::MODE_IDLE;
            line_next    = line_inc;
            column_next  = '0;
            run_next     = '0;
        end
        else
        begin
            column_next = col_inc;
            unique case (mode) inside
                nil_pkg::MODE_COMMENT:
                begin
                end
                nil_pkg::MODE_SKIP:
                begin
                    if (is_blank)
                        mode_next = nil_pkg::MODE_IDLE;
                end
                nil_pkg::MODE_NUM, nil_pkg::MODE_IDENT:
                begin
                    if (is_digit || ((mode == nil_pkg::MODE_IDENT) && is_letter))
                    begin
                        run_next = run_inc;
                    end
                    else if (is_blank || is_hash)
                    begin
                        result.valid = 1'b1;
                        mode_next    = is_hash ? nil_pkg::MODE_COMMENT : nil_pkg::MODE_IDLE;
                        run_next     = '0;
                    end
                    else
                    begin
                        result.valid   = 1'b1;
                        result.kind    = nil_pkg::KIND_BAD;
                        result.col_no  = col_out;
                        result.tok_len = '0;
                        mode_next      = nil_pkg::MODE_SKIP;
                        run_next       = '0;
                    end
                end
                default:
                begin
                    if (is_blank)
                    begin
                        mode_next = nil_pkg::MODE_IDLE;
                    end
                    else if (is_hash)
                    begin
                        mode_next = nil_pkg::MODE_COMMENT;
                    end
                    else if (is_digit || is_letter)
                    begin
                        mode_next  = is_digit ? nil_pkg::MODE_NUM : nil_pkg::MODE_IDENT;
                        start_next = col_inc;
                        run_next   = CNT_ONE;
                    end
                    else
                    begin
                        result.valid   = 1'b1;
                        result.kind    = nil_pkg::KIND_BAD;
                        result.col_no  = col_out;
                        result.tok_len = '0;
                        mode_next      = nil_pkg::MODE_SKIP;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/nil_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nil_checker: port-level checks of the lexer
// Watch the token channel for stability under stall and for consistent
// result fields.
// ----------------------------------------------------------------------------
module nil_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire nil_pkg::kind_t                 out_kind,
    input wire logic [nil_pkg::FIELD_BITS-1:0] out_line_no,
    input wire logic [nil_pkg::FIELD_BITS-1:0] out_col_no,
    input wire logic [nil_pkg::FIELD_BITS-1:0] out_tok_len
);

    // Hold a stalled request and its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_line_no) && $stable(out_col_no) && $stable(out_tok_len))
        else $error("token request dropped or changed while stalled");

    // A malformed result carries no length and points at a real column
    a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == nil_pkg::KIND_BAD) |-> (out_tok_len == '0)
            && (out_col_no != '0) && (out_line_no != '0))
        else $error("malformed result with bad fields");

    // A token has at least one character and starts in a real column
    a_tok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != nil_pkg::KIND_BAD) |-> (out_tok_len != '0)
            && (out_col_no != '0) && (out_line_no != '0))
        else $error("token result with empty length or zero position");

    // Ready drops only while a result waits in the output register
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("character channel stalled with no pending result");

    // A stalled character side frees up once the sink takes a result
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_valid && out_ready |=> in_ready)
        else $error("character channel still stalled after a result was taken");

    wire unused_in_valid = in_valid;

endmodule

bind number_identifier_lexer_unit nil_checker u_nil_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (char_in.valid),
    .in_ready    (char_in.ready),
    .out_valid   (tok_out.valid),
    .out_ready   (tok_out.ready),
    .out_kind    (tok_out.kind),
    .out_line_no (tok_out.line_no),
    .out_col_no  (tok_out.col_no),
    .out_tok_len (tok_out.tok_len)
);
`default_nettype wire

FILE: tb/number_identifier_lexer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_identifier_lexer_unit_checker: token predictor and scoreboard
// Watches the character and token channels and runs its own model of the
// lexer on every accepted character. Each accepted token is compared, field
// by field, with the oldest predicted token.
// ----------------------------------------------------------------------------
module number_identifier_lexer_unit_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nil_char_if         char_mon,
    nil_tok_if          tok_mon,
    output int unsigned pending,
    output int unsigned fail_count
);

    typedef logic [nil_pkg::COUNT_BITS-1:0] count_t;
    typedef logic [nil_pkg::FIELD_BITS-1:0] field_t;

    typedef struct packed {
        nil_pkg::kind_t kind;
        field_t         line_no;
        field_t         col_no;
        field_t         tok_len;
    } token_t;

    token_t      expected_tokens[$];
    int unsigned mismatches;

    nil_pkg::mode_t lex_mode;
    count_t         line_cnt;
    count_t         col_cnt;
    count_t         tok_start;
    count_t         tok_run;

    function automatic count_t bump(input count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Clamp a counter to the width of a reported field.
    function automatic field_t clamp(input count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'hFFFF) ? 16'hFFFF : wide[nil_pkg::FIELD_BITS-1:0];
    endfunction

    task automatic clear_lexer();
        lex_mode  = nil_pkg::MODE_IDLE;
        line_cnt  = count_t'(1);
        col_cnt   = '0;
        tok_start = '0;
        tok_run   = '0;
    endtask

    task automatic emit(input nil_pkg::kind_t k, input count_t col, input count_t len);
        token_t t;
        t.kind    = k;
        t.line_no = clamp(line_cnt);
        t.col_no  = clamp(col);
        t.tok_len = clamp(len);
        expected_tokens.push_back(t);
    endtask

    // Advance the lexer by one character and queue any token it yields.
    task automatic lex_step(input logic [7:0] c, input logic eoi);
        logic digit;
        logic letter;
        logic blank;
        digit  = (c >= nil_pkg::CH_DIGIT_LO) && (c <= nil_pkg::CH_DIGIT_HI);
        letter = ((c >= nil_pkg::CH_UPPER_LO) && (c <= nil_pkg::CH_UPPER_HI)) ||
                 ((c >= nil_pkg::CH_LOWER_LO) && (c <= nil_pkg::CH_LOWER_HI));
        blank  = (c == nil_pkg::CH_SPACE) || (c == nil_pkg::CH_TAB);
        if (eoi)
        begin
            if (lex_mode == nil_pkg::MODE_NUM)
                emit(nil_pkg::KIND_NUM, tok_start, tok_run);
            else if (lex_mode == nil_pkg::MODE_IDENT)
                emit(nil_pkg::KIND_IDENT, tok_start, tok_run);
            clear_lexer();
        end
        else if (c == nil_pkg::CH_NEWLINE)
        begin
            if (lex_mode == nil_pkg::MODE_NUM)
                emit(nil_pkg::KIND_NUM, tok_start, tok_run);
            else if (lex_mode == nil_pkg::MODE_IDENT)
                emit(nil_pkg::KIND_IDENT, tok_start, tok_run);
            line_cnt = bump(line_cnt);
            col_cnt  = '0;
            lex_mode = nil_pkg::MODE_IDLE;
            tok_run  = '0;
        end
        else
        begin
            col_cnt = bump(col_cnt);
            case (lex_mode) inside
                nil_pkg::MODE_COMMENT: ;
                nil_pkg::MODE_SKIP:
                begin
                    if (blank)
                        lex_mode = nil_pkg::MODE_IDLE;
                end
                nil_pkg::MODE_NUM, nil_pkg::MODE_IDENT:
                begin
                    if (digit || (lex_mode == nil_pkg::MODE_IDENT && letter))
                        tok_run = bump(tok_run);
                    else if (blank || c == nil_pkg::CH_HASH)
                    begin
                        emit((lex_mode == nil_pkg::MODE_NUM) ? nil_pkg::KIND_NUM
                                                             : nil_pkg::KIND_IDENT,
                             tok_start, tok_run);
                        lex_mode = (c == nil_pkg::CH_HASH) ? nil_pkg::MODE_COMMENT
                                                           : nil_pkg::MODE_IDLE;
                        tok_run  = '0;
                    end
                    else
                    begin
                        emit(nil_pkg::KIND_BAD, col_cnt, '0);
                        lex_mode = nil_pkg::MODE_SKIP;
                        tok_run  = '0;
                    end
                end
                default:
                begin
                    if (blank)
                        lex_mode = nil_pkg::MODE_IDLE;
                    else if (c == nil_pkg::CH_HASH)
                        lex_mode = nil_pkg::MODE_COMMENT;
                    else if (digit || letter)
                    begin
                        lex_mode  = digit ? nil_pkg::MODE_NUM : nil_pkg::MODE_IDENT;
                        tok_start = col_cnt;
                        tok_run   = count_t'(1);
                    end
                    else
                    begin
                        emit(nil_pkg::KIND_BAD, col_cnt, '0);
                        lex_mode = nil_pkg::MODE_SKIP;
                    end
                end
            endcase
        end
    endtask

    task automatic compare_field(input string name, input field_t want, input field_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        if (!rst_n)
        begin
            clear_lexer();
            expected_tokens.delete();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Check first: a token leaving now never belongs to the character
            // taken at this same edge.
            if (tok_mon.valid && tok_mon.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d line %0d col %0d len %0d",
                           tok_mon.kind, tok_mon.line_no, tok_mon.col_no,
                           tok_mon.tok_len);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(tok_mon.kind));
                    compare_field("line_no", want.line_no, tok_mon.line_no);
                    compare_field("col_no", want.col_no, tok_mon.col_no);
                    compare_field("tok_len", want.tok_len, tok_mon.tok_len);
                end
            end
            if (char_mon.valid && char_mon.ready)
                lex_step(char_mon.ch, char_mon.end_of_input);
            pending    <= expected_tokens.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: tb/number_identifier_lexer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_identifier_lexer_unit_tb: top of the lexer testbench
// Drives character requests with random gaps, stalls the token side at
// random, and walks the lexer through hand-picked cases and a long stretch
// of random words, noise and broken words. The checker beside the block
// predicts and compares every token.
// ----------------------------------------------------------------------------
module number_identifier_lexer_unit_tb;

    localparam int CLK_PERIOD = 8;
    localparam int RANDOM_REQUESTS = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Kill idling on both sides while set.
    logic quiet = 1'b0;
    int unsigned chars_sent = 0;
    int unsigned stall_left;
    int unsigned pending;
    int unsigned fail_count;

    nil_char_if char_if ();
    nil_tok_if  tok_if ();

    number_identifier_lexer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_if),
        .tok_out (tok_if)
    );

    number_identifier_lexer_unit_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_mon   (char_if),
        .tok_mon    (tok_if),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'(nil_pkg::CH_UPPER_LO + $urandom_range(0, 25));
        return 8'(nil_pkg::CH_LOWER_LO + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 2) == 0)
            return 8'(nil_pkg::CH_DIGIT_LO + $urandom_range(0, 9));
        return rand_letter();
    endfunction

    // Token sink: hold ready low for random stretches, none started while quiet.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tok_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            tok_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) < 3)
        begin
            tok_if.ready <= 1'b0;
            stall_left   <= pick_gap();
        end
        else
            tok_if.ready <= 1'b1;
    end

    // Send one character request. Idle cycles carry random junk on the data
    // lines so the lexer must ignore them. Valid is only lowered when a gap
    // follows, so it never toggles twice in one step.
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            char_if.valid        <= 1'b0;
            char_if.ch           <= 8'($urandom);
            char_if.end_of_input <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        char_if.valid        <= 1'b1;
        char_if.ch           <= c;
        char_if.end_of_input <= eoi;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // Drop valid and hold until the checker has seen every predicted token.
    // The first edge lets the last prediction land in the pending count.
    task automatic drain();
        char_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One random word: mostly well-formed numbers, identifiers and comments,
    // the rest broken words, raw noise, single tabs or newlines and end of input.
    task automatic send_word();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_char(8'(nil_pkg::CH_DIGIT_LO + $urandom_range(0, 9)), 1'b0);
        end
        else if (pick < 56)
        begin
            send_char(rand_letter(), 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send_char(rand_alnum(), 1'b0);
        end
        else if (pick < 66)
        begin
            send_char(nil_pkg::CH_HASH, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send_char(8'($urandom_range(0, 255)), 1'b0);
            send_char(nil_pkg::CH_NEWLINE, 1'b0);
        end
        else if (pick < 78)
        begin
            // Broken word: a run with a stray byte, then more of the word.
            n = $urandom_range(1, 3);
            repeat (n) send_char(rand_alnum(), 1'b0);
            send_char(8'($urandom_range(0, 255)), 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) send_char(rand_alnum(), 1'b0);
        end
        else if (pick < 90)
            send_char(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 97)
            send_char($urandom_range(0, 1) ? nil_pkg::CH_TAB : nil_pkg::CH_NEWLINE, 1'b0);
        else
            send_char(8'($urandom_range(0, 255)), 1'b1);

        // Separator: usually a blank, sometimes a newline or '#', sometimes
        // none so that words run into each other.
        pick = $urandom_range(0, 99);
        if (pick < 55)
            send_char(nil_pkg::CH_SPACE, 1'b0);
        else if (pick < 65)
            send_char(nil_pkg::CH_TAB, 1'b0);
        else if (pick < 80)
            send_char(nil_pkg::CH_NEWLINE, 1'b0);
        else if (pick < 85)
            send_char(nil_pkg::CH_HASH, 1'b0);
    endtask

    // Abort a hung run.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int unsigned random_start;
        int unsigned words;
        char_if.valid        = 1'b0;
        char_if.ch           = 8'h00;
        char_if.end_of_input = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases.
        // Number closed by a blank, identifier with a digit closed by a tab.
        send_text("7 ab1\t");
        // Letter inside a number is malformed; the skip swallows '#' and the
        // rest of the word, a blank ends it, and a newline closes a number.
        send_text("12a$#x 9\n");
        // Identifier closed by '#', which opens a comment to end of line.
        send_text("Zz9#c 5\n");
        // Extreme bytes: 0xFF is malformed, 0x00 is swallowed by the skip.
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(nil_pkg::CH_NEWLINE, 1'b0);
        // End of input flushes a pending identifier; its byte is ignored.
        send_char(8'h71, 1'b0);
        send_char(8'hFF, 1'b1);
        // End of input inside a comment, then inside a skip.
        send_char(nil_pkg::CH_HASH, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'h25, 1'b0);
        send_char(8'h00, 1'b1);
        // End of input flushes a pending number.
        send_char(nil_pkg::CH_DIGIT_LO, 1'b0);
        send_char(8'h00, 1'b1);

        // Hold the sender until all directed tokens are back.
        drain();

        // Random words with idling, broken up by short stretches without
        // any idling and one more full drain half way.
        random_start = chars_sent;
        words = 0;
        while (chars_sent - random_start < RANDOM_REQUESTS)
        begin
            if (words % 50 == 20)
                quiet <= 1'b1;
            else if (words % 50 == 30)
                quiet <= 1'b0;
            if (words == 60)
                drain();
            send_word();
            words++;
        end
        quiet <= 1'b0;
        send_char(8'($urandom), 1'b1);

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/nil_pkg.sv
rtl/nil_if.sv
rtl/nil_step.sv
rtl/number_identifier_lexer_unit.sv
rtl/nil_checker.sv
tb/number_identifier_lexer_unit_checker.sv
tb/number_identifier_lexer_unit_tb.sv
